/* src/size_class_slab_allocator_unit_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_UNIT_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_UNIT_MACROS_SVH

`define SCSA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SCSA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/scsa_pkg.sv */
`timescale 1ns / 1ps
package scsa_pkg;
    localparam int NUM_CLASSES_DEF  = 4;
    localparam int FREE_DEPTH_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FALLBACK  = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;

    localparam logic [2:0] REG_CLASS0       = 3'd0;
    localparam logic [2:0] REG_CLASS3       = 3'd3;
    localparam logic [2:0] REG_BLOCK_BYTES  = 3'd4;
    localparam logic [2:0] REG_REGION_BASE  = 3'd5;
    localparam logic [2:0] REG_REGION_BYTES = 3'd6;

    localparam int DIV_STEPS = 33;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_POP_RD, S_POP_WAIT, S_PUSH, S_OPEN_CHK, S_DIV,
        S_OPEN_SET, S_CARVE, S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic push;
        logic pop_rd;
        logic pop_take;
        logic open_chk;
        logic div_start;
        logic open_set;
        logic carve;
        logic [2:0] set_status;
        logic set_status_en;
        logic out_valid_set;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic invalid;
        logic no_class;
        logic is_free;
        logic stack_full;
        logic stack_empty;
        logic need_open;
        logic open_fail;
        logic div_done;
        logic out_busy;
    } stat_t;
endpackage

/* src/scsa_ram.sv */
`timescale 1ns / 1ps
module scsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
    assign rdata = rdata_reg;
endmodule

/* src/scsa_div.sv */
`timescale 1ns / 1ps
module scsa_div
    import scsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] remainder
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] trial;

    always_comb begin
        trial     = {rem_reg[15:0], quo_reg[32]};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            cnt_next  = 6'(DIV_STEPS);
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[31:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial - {1'b0, divisor};
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[15:0];
endmodule

/* src/scsa_ctrl.sv */
`timescale 1ns / 1ps
`include "size_class_slab_allocator_unit_macros.svh"
module scsa_ctrl
    import scsa_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t st,
    output cmd_t  cmd
);
    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (st.invalid || st.no_class) state_next = S_DONE;
                else if (st.is_free) state_next = st.stack_full ? S_DONE : S_PUSH;
                else if (!st.stack_empty) state_next = S_POP_RD;
                else if (st.need_open) state_next = S_OPEN_CHK;
                else state_next = S_CARVE;
            end
            S_POP_RD:   state_next = S_POP_WAIT;
            S_POP_WAIT: state_next = S_DONE;
            S_PUSH:     state_next = S_DONE;
            S_OPEN_CHK: state_next = st.open_fail ? S_DONE : S_DIV;
            S_DIV: begin
                if (st.div_done) state_next = S_OPEN_SET;
            end
            S_OPEN_SET: state_next = S_CARVE;
            S_CARVE:    state_next = S_DONE;
            S_DONE: begin
                if (!st.out_busy) state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECIDE: begin
                cmd.set_status_en = 1'b1;
                if (st.invalid) cmd.set_status = ST_INVALID;
                else if (st.no_class) cmd.set_status = ST_FALLBACK;
                else if (st.is_free && st.stack_full) cmd.set_status = ST_FULL;
                else cmd.set_status = ST_OK;
            end
            S_POP_RD:   cmd.pop_rd = 1'b1;
            S_POP_WAIT: cmd.pop_take = 1'b1;
            S_PUSH:     cmd.push = 1'b1;
            S_OPEN_CHK: begin
                cmd.open_chk = 1'b1;
                cmd.div_start = !st.open_fail;
                cmd.set_status_en = st.open_fail;
                cmd.set_status = ST_EXHAUSTED;
            end
            S_OPEN_SET: cmd.open_set = 1'b1;
            S_CARVE:    cmd.carve = 1'b1;
            S_DONE:     cmd.out_valid_set = !st.out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    `SCSA_ASSERT_IMP(a_ready_idle, aclk, aresetn, in_ready, state_reg == S_IDLE)
    `SCSA_ASSERT_NXT(a_load_decide, aclk, aresetn, cmd.load, state_reg == S_DECIDE)
    `SCSA_ASSERT_NXT(a_pop_wait, aclk, aresetn, cmd.pop_rd, cmd.pop_take)
endmodule

/* src/scsa_dp.sv */
`timescale 1ns / 1ps
`include "size_class_slab_allocator_unit_macros.svh"
module scsa_dp
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
    parameter int FREE_DEPTH   = FREE_DEPTH_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_action,
    input  logic [15:0] in_size,
    input  logic [31:0] in_addr,
    input  cmd_t        cmd,
    output stat_t       st,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_slot_address,
    output logic [2:0]  out_status,
    output logic [1:0]  out_class_index,
    output logic        out_reused
);
    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int DW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int NW = $clog2(FREE_DEPTH + 1);
    localparam int MD = NUM_CLASSES * FREE_DEPTH;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;

    logic [15:0] class_size_reg [NUM_CLASSES];
    logic [20:0] block_bytes_reg;
    logic [31:0] region_base_reg, region_bytes_reg;
    logic [32:0] cursor_reg [NUM_CLASSES];
    logic [32:0] limit_reg  [NUM_CLASSES];
    logic        open_reg   [NUM_CLASSES];
    logic [NW-1:0] count_reg [NUM_CLASSES];
    logic [32:0] used_reg;

    logic        action_reg;
    logic [15:0] size_reg;
    logic [31:0] addr_reg;
    logic        found;
    logic [CW-1:0] cls, cls_reg;
    logic [15:0] slot;
    logic [32:0] bsize_reg, start_reg, body_reg;
    logic [33:0] minb, bsize, start, end_used, end_addr;

    logic        ov_reg;
    logic [31:0] oaddr_reg;
    logic [2:0]  ostat_reg;
    logic        oreused_reg;
    logic [31:0] out_addr_reg;
    logic [2:0]  out_stat_reg;
    logic [1:0]  out_cls_reg;
    logic        out_reused_reg;
    logic        div_done;
    logic [15:0] rem;
    logic [31:0] rd;

    always_comb begin
        found = 1'b0;
        cls = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            logic ok;
            ok = 1'b1;
            for (int j = 0; j <= k; j++) begin
                if (class_size_reg[j] == 16'd0) ok = 1'b0;
            end
            if (ok && class_size_reg[k] >= size_reg) begin
                found = 1'b1;
                cls = CW'(k);
            end
        end
    end

    assign slot = class_size_reg[cls_reg];
    assign minb = 34'(HEADER_BYTES) + {17'd0, slot, 1'b0} - 34'd1;
    assign bsize = ({13'd0, block_bytes_reg} < minb) ? minb : {13'd0, block_bytes_reg};
    assign start = {2'd0, region_base_reg} + {1'b0, used_reg};
    assign end_used = {1'b0, used_reg} + bsize;
    assign end_addr = start + bsize;

    assign st.invalid = (size_reg == 16'd0) || (action_reg && addr_reg == 32'd0);
    assign st.no_class = !found;
    assign st.is_free = action_reg;
    assign st.stack_full = count_reg[cls] >= NW'(FREE_DEPTH);
    assign st.stack_empty = count_reg[cls] == '0;
    assign st.need_open = !open_reg[cls] || cursor_reg[cls] >= limit_reg[cls];
    assign st.open_fail = (end_used > {2'd0, region_bytes_reg}) || (end_addr > 34'h100000000);
    assign st.div_done = div_done;
    assign st.out_busy = ov_reg && !out_ready;

    scsa_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(start[32:0] + 33'(HEADER_BYTES)), .divisor(slot),
        .done(div_done), .remainder(rem)
    );

    logic [AW-1:0] waddr, raddr;
    logic [NW-1:0] cnt;
    assign cnt = count_reg[cls_reg];
    assign waddr = AW'(cls_reg) * AW'(FREE_DEPTH) + AW'(cnt[DW-1:0]);
    assign raddr = AW'(cls_reg) * AW'(FREE_DEPTH) + AW'(cnt - NW'(1));

    scsa_ram #(.WIDTH(32), .DEPTH(MD)) u_ram (
        .aclk(aclk), .we(cmd.push), .waddr(waddr), .wdata(addr_reg),
        .raddr(raddr), .rdata(rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                class_size_reg[k] <= '0;
                cursor_reg[k] <= '0;
                limit_reg[k] <= '0;
                open_reg[k] <= 1'b0;
                count_reg[k] <= '0;
            end
            block_bytes_reg <= 21'd4096;
            region_base_reg <= '0;
            region_bytes_reg <= '0;
            used_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index <= REG_CLASS3) begin
                    if (32'(cfg_index) < NUM_CLASSES)
                        class_size_reg[CW'(cfg_index)] <= cfg_data[15:0];
                end else if (cfg_index == REG_BLOCK_BYTES) block_bytes_reg <= cfg_data[20:0];
                else if (cfg_index == REG_REGION_BASE) region_base_reg <= cfg_data;
                else if (cfg_index == REG_REGION_BYTES) region_bytes_reg <= cfg_data;
            end
            if (cmd.push) count_reg[cls_reg] <= cnt + NW'(1);
            if (cmd.pop_rd) count_reg[cls_reg] <= cnt - NW'(1);
            if (cmd.open_chk && !st.open_fail) begin
                used_reg <= end_used[32:0];
                bsize_reg <= bsize[32:0];
                start_reg <= start[32:0];
                body_reg <= start[32:0] + 33'(HEADER_BYTES);
            end
            if (cmd.open_set) begin
                cursor_reg[cls_reg] <= (rem == 16'd0) ? body_reg
                                       : body_reg + {17'd0, slot - rem};
                limit_reg[cls_reg] <= start_reg + bsize_reg - {17'd0, slot} + 33'd1;
                open_reg[cls_reg] <= 1'b1;
            end
            if (cmd.carve) cursor_reg[cls_reg] <= cursor_reg[cls_reg] + {17'd0, slot};
            if (cmd.out_valid_set) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
        if (cmd.load) begin
            action_reg <= in_action;
            size_reg <= in_size;
            addr_reg <= in_addr;
            oaddr_reg <= '0;
            oreused_reg <= 1'b0;
        end
        if (cmd.set_status_en) begin
            ostat_reg <= cmd.set_status;
            cls_reg <= (st.invalid || st.no_class) ? cls_reg : cls;
        end
        if (cmd.pop_take) begin
            oaddr_reg <= rd;
            oreused_reg <= 1'b1;
        end
        if (cmd.carve) oaddr_reg <= cursor_reg[cls_reg][31:0];
    end

    logic clsz;
    always_ff @(posedge aclk) begin
        if (cmd.set_status_en && cmd.set_status != ST_EXHAUSTED)
            clsz <= st.invalid || st.no_class;
    end

    // result held stable while the next transaction is worked on
    always_ff @(posedge aclk) begin
        if (cmd.out_valid_set) begin
            out_addr_reg <= oaddr_reg;
            out_stat_reg <= ostat_reg;
            out_cls_reg <= clsz ? 2'd0 : 2'(cls_reg);
            out_reused_reg <= oreused_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_slot_address = out_addr_reg;
    assign out_status = out_stat_reg;
    assign out_class_index = out_cls_reg;
    assign out_reused = out_reused_reg;

    `SCSA_ASSERT_NXT(a_carve_adv, aclk, aresetn, cmd.carve,
        oaddr_reg == $past(cursor_reg[cls_reg][31:0]))
    `SCSA_ASSERT_IMP(a_one_op, aclk, aresetn, cmd.push, !cmd.pop_rd && !cmd.carve)
    `SCSA_ASSERT_IMP(a_reuse_ok, aclk, aresetn, out_valid && out_reused,
        out_status == ST_OK)
endmodule

/* src/size_class_slab_allocator_unit.sv */
`timescale 1ns / 1ps
// channel | direction | handshake              | payload
// s_      | in        | s_tvalid/s_tready      | s_tdata, s_tuser
// m_      | out       | m_tvalid/m_tready      | m_tdata
// cfg     | in        | cfg_we                 | cfg_index, cfg_data
// One transaction at a time; opening a new block runs the 33-step
// remainder divider. Reset is synchronous active low and clears
// all counters and block state. A stalled result lets the next transaction
// run, then holds it in its final state until the output frees.
module size_class_slab_allocator_unit
    import scsa_pkg::*;
#(
    parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
    parameter int FREE_DEPTH   = FREE_DEPTH_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // request_size[15:0], free_address[47:16]
    input  logic        s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // slot_address, status, class_index, reused, pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    cmd_t  cmd;
    stat_t st;
    logic [31:0] sa;
    logic [2:0]  stv;
    logic [1:0]  ci;
    logic        ru;

    scsa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .st(st), .cmd(cmd)
    );

    scsa_dp #(.NUM_CLASSES(NUM_CLASSES), .FREE_DEPTH(FREE_DEPTH),
              .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_action(s_tuser), .in_size(s_tdata[15:0]),
        .in_addr(s_tdata[47:16]), .cmd(cmd), .st(st), .out_valid(m_tvalid),
        .out_ready(m_tready), .out_slot_address(sa), .out_status(stv),
        .out_class_index(ci), .out_reused(ru)
    );

    assign m_tdata = {2'b00, ru, ci, stv, sa};
endmodule
